/* rtl/csi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// csi_pkg
// Shared constants for the circle and segment intersection pipeline.
// -----------------------------------------------------------------------------
package csi_pkg;

  localparam int CSI_COORD_WIDTH = 31;
  localparam int RADIUS_WIDTH    = 30;
  localparam int RSQ_WIDTH       = 2 * RADIUS_WIDTH;
  localparam int DIV_LANES       = 4;

endpackage
`default_nettype wire

/* rtl/csi_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// csi_sqrt_cell
// One bit of a digit-by-digit square root, registered toward the next cell.
// -----------------------------------------------------------------------------
module csi_sqrt_cell #(
  parameter int VAL_WIDTH  = 8,
  parameter int ROOT_WIDTH = 4,
  parameter int BIT_INDEX  = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [VAL_WIDTH-1:0]  in_rem,
  input  logic [ROOT_WIDTH-1:0] in_root,
  output logic                  out_valid,
  output logic [VAL_WIDTH-1:0]  out_rem,
  output logic [ROOT_WIDTH-1:0] out_root
);

  logic [VAL_WIDTH:0] trial;
  logic               take;

  always_comb begin
    trial = ((VAL_WIDTH + 1)'(in_root) << (BIT_INDEX + 1))
          | ((VAL_WIDTH + 1)'(1) << (2 * BIT_INDEX));
    take  = {1'b0, in_rem} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? in_rem - trial[VAL_WIDTH-1:0] : in_rem;
      out_root <= take ? in_root | (ROOT_WIDTH'(1) << BIT_INDEX) : in_root;
    end
  end

endmodule
`default_nettype wire

/* rtl/csi_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// csi_div_cell
// One quotient bit of a restoring division for all lanes over a shared divisor.
// -----------------------------------------------------------------------------
module csi_div_cell import csi_pkg::*; #(
  parameter int NUM_WIDTH = 16,
  parameter int DEN_WIDTH = 8,
  parameter int QUO_WIDTH = 8,
  parameter int BIT_INDEX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [DEN_WIDTH-1:0]                in_den,
  input  logic [DIV_LANES-1:0][NUM_WIDTH-1:0] in_rem,
  input  logic [DIV_LANES-1:0][QUO_WIDTH-1:0] in_quo,
  output logic                                out_valid,
  output logic [DEN_WIDTH-1:0]                out_den,
  output logic [DIV_LANES-1:0][NUM_WIDTH-1:0] out_rem,
  output logic [DIV_LANES-1:0][QUO_WIDTH-1:0] out_quo
);

  logic [NUM_WIDTH-1:0] shifted;

  assign shifted = NUM_WIDTH'(in_den) << BIT_INDEX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den <= in_den;
      for (int l = 0; l < DIV_LANES; l++) begin
        if (in_rem[l] >= shifted) begin
          out_rem[l] <= in_rem[l] - shifted;
          out_quo[l] <= in_quo[l] | (QUO_WIDTH'(1) << BIT_INDEX);
        end else begin
          out_rem[l] <= in_rem[l];
          out_quo[l] <= in_quo[l];
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/circle_segment_intersection.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// circle_segment_intersection
// Streaming intersection of a line segment with a circle.
// -----------------------------------------------------------------------------
// The block takes one beat per clock while the output skid stage is empty
// and returns one result beat per input beat, in order. The pipeline runs
// through a row of RB square root cells, one per root bit, where RB is half
// the discriminant width rounded up (63 at the default width), and a row of
// division cells, one per quotient bit. An output skid stage holds a finished
// result that is not taken; while it is full, s_tready is low and all stall.
// -----------------------------------------------------------------------------
module circle_segment_intersection import csi_pkg::*; #(
  parameter  int COORD_WIDTH = CSI_COORD_WIDTH,
  localparam int IN_W  = ((6 * COORD_WIDTH + RADIUS_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, origin_x, origin_y,
  // circle_radius
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // hit_count, first_x, first_y, second_x, second_y
  output logic [OUT_W-1:0] m_tdata
);

  localparam int W    = COORD_WIDTH;
  localparam int PW   = 2 * W + 2;
  localparam int AW   = 2 * W + 1;
  localparam int CW   = 2 * W + 1;
  localparam int CL   = (CW > 64) ? 64 : CW;
  localparam int CLO  = (CL + 1) / 2;
  localparam int CHI  = CL - CLO;
  localparam int C2W  = 2 * CL;
  localparam int AL   = (AW + 1) / 2;
  localparam int AH   = AW - AL;
  localparam int R2H  = RSQ_WIDTH / 2;
  localparam int ARW  = AW + RSQ_WIDTH;
  localparam int CMPW = (ARW > C2W) ? ARW : C2W;
  localparam int SQW  = ARW + 2 + (ARW % 2);
  localparam int RB   = SQW / 2;
  localparam int RTW  = (((2 * W + 3) > RB) ? (2 * W + 3) : RB) + 2;
  localparam int NBW  = 2 * W + 2;
  localparam int NL   = (NBW + 1) / 2;
  localparam int NH   = NBW - NL;
  localparam int NUMW = NBW + W;
  localparam int QB   = W;

  logic en;
  logic skid_v;
  logic [OUT_W-1:0] skid;
  logic out_v;
  logic [OUT_W-1:0] out_d;

  assign en       = !skid_v;
  assign s_tready = en;
  assign m_tvalid = skid_v || out_v;
  assign m_tdata  = skid_v ? skid : out_d;

  // Front end.
  logic [W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [RADIUS_WIDTH-1:0] in_r;

  assign in_ax = s_tdata[W-1:0];
  assign in_ay = s_tdata[2*W-1:W];
  assign in_bx = s_tdata[3*W-1:2*W];
  assign in_by = s_tdata[4*W-1:3*W];
  assign in_cx = s_tdata[5*W-1:4*W];
  assign in_cy = s_tdata[6*W-1:5*W];
  assign in_r  = s_tdata[6*W+RADIUS_WIDTH-1:6*W];

  logic v1, v2, v3, v4, v5, v6;

  logic signed [W:0] st1_dx, st1_dy, st1_fx, st1_fy;
  logic [W-1:0] st1_ax, st1_ay;
  logic [RADIUS_WIDTH-1:0] st1_r;

  logic signed [PW-1:0] st2_dxdx, st2_dydy, st2_fxdx, st2_fydy, st2_fxdy, st2_fydx;
  logic [RSQ_WIDTH-1:0] st2_rsq;
  logic signed [W:0] st2_dx, st2_dy;
  logic [W-1:0] st2_ax, st2_ay;

  logic signed [PW-1:0] st2_cross;
  logic [AW-1:0] st3_a;
  logic signed [PW-1:0] st3_bh;
  logic [CW-1:0] st3_cr;
  logic [RSQ_WIDTH-1:0] st3_rsq;
  logic signed [W:0] st3_dx, st3_dy;
  logic [W-1:0] st3_ax, st3_ay;

  logic [CL-1:0] st3_crl;
  logic [AL+R2H-1:0] st4_all, st4_alh;
  logic [AH+R2H-1:0] st4_ahl, st4_ahh;
  logic [2*CLO-1:0] st4_cll;
  logic [CLO+CHI-1:0] st4_clh;
  logic [2*CHI-1:0] st4_chh;
  logic st4_big, st4_az;
  logic [AW-1:0] st4_a;
  logic signed [PW-1:0] st4_bh;
  logic signed [W:0] st4_dx, st4_dy;
  logic [W-1:0] st4_ax, st4_ay;

  logic [ARW-1:0] st5_ar2;
  logic [C2W-1:0] st5_cr2;
  logic st5_big, st5_az;
  logic [AW-1:0] st5_a;
  logic signed [PW-1:0] st5_bh;
  logic signed [W:0] st5_dx, st5_dy;
  logic [W-1:0] st5_ax, st5_ay;

  logic st5_ok;
  logic [CMPW-1:0] st5_diff;
  logic [SQW-1:0] st6_disc;
  logic st6_ok;
  logic [AW-1:0] st6_a;
  logic signed [PW-1:0] st6_bh;
  logic signed [W:0] st6_dx, st6_dy;
  logic [W-1:0] st6_ax, st6_ay;

  assign st2_cross = st2_fxdy - st2_fydx;
  assign st3_crl   = st3_cr[CL-1:0];
  assign st5_ok    = !st5_big && !st5_az && (CMPW'(st5_ar2) >= CMPW'(st5_cr2));
  assign st5_diff  = CMPW'(st5_ar2) - CMPW'(st5_cr2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_dx <= $signed({in_bx[W-1], in_bx}) - $signed({in_ax[W-1], in_ax});
      st1_dy <= $signed({in_by[W-1], in_by}) - $signed({in_ay[W-1], in_ay});
      st1_fx <= $signed({in_ax[W-1], in_ax}) - $signed({in_cx[W-1], in_cx});
      st1_fy <= $signed({in_ay[W-1], in_ay}) - $signed({in_cy[W-1], in_cy});
      st1_ax <= in_ax;
      st1_ay <= in_ay;
      st1_r  <= in_r;

      st2_dxdx <= st1_dx * st1_dx;
      st2_dydy <= st1_dy * st1_dy;
      st2_fxdx <= st1_fx * st1_dx;
      st2_fydy <= st1_fy * st1_dy;
      st2_fxdy <= st1_fx * st1_dy;
      st2_fydx <= st1_fy * st1_dx;
      st2_rsq  <= RSQ_WIDTH'(st1_r) * RSQ_WIDTH'(st1_r);
      st2_dx   <= st1_dx;
      st2_dy   <= st1_dy;
      st2_ax   <= st1_ax;
      st2_ay   <= st1_ay;

      st3_a   <= AW'(st2_dxdx + st2_dydy);
      st3_bh  <= st2_fxdx + st2_fydy;
      st3_cr  <= st2_cross[PW-1] ? CW'(-st2_cross) : CW'(st2_cross);
      st3_rsq <= st2_rsq;
      st3_dx  <= st2_dx;
      st3_dy  <= st2_dy;
      st3_ax  <= st2_ax;
      st3_ay  <= st2_ay;

      st4_all <= (AL+R2H)'(st3_a[AL-1:0]) * (AL+R2H)'(st3_rsq[R2H-1:0]);
      st4_alh <= (AL+R2H)'(st3_a[AL-1:0]) * (AL+R2H)'(st3_rsq[RSQ_WIDTH-1:R2H]);
      st4_ahl <= (AH+R2H)'(st3_a[AW-1:AL]) * (AH+R2H)'(st3_rsq[R2H-1:0]);
      st4_ahh <= (AH+R2H)'(st3_a[AW-1:AL]) * (AH+R2H)'(st3_rsq[RSQ_WIDTH-1:R2H]);
      st4_cll <= (2*CLO)'(st3_crl[CLO-1:0]) * (2*CLO)'(st3_crl[CLO-1:0]);
      st4_clh <= (CLO+CHI)'(st3_crl[CLO-1:0]) * (CLO+CHI)'(st3_crl[CL-1:CLO]);
      st4_chh <= (2*CHI)'(st3_crl[CL-1:CLO]) * (2*CHI)'(st3_crl[CL-1:CLO]);
      st4_big <= (st3_cr >> 64) != '0;
      st4_az  <= st3_a == '0;
      st4_a   <= st3_a;
      st4_bh  <= st3_bh;
      st4_dx  <= st3_dx;
      st4_dy  <= st3_dy;
      st4_ax  <= st3_ax;
      st4_ay  <= st3_ay;

      st5_ar2 <= ARW'(st4_all) + (ARW'(st4_alh) << R2H) + (ARW'(st4_ahl) << AL)
               + (ARW'(st4_ahh) << (AL + R2H));
      st5_cr2 <= C2W'(st4_cll) + (C2W'(st4_clh) << (CLO + 1))
               + (C2W'(st4_chh) << (2 * CLO));
      st5_big <= st4_big;
      st5_az  <= st4_az;
      st5_a   <= st4_a;
      st5_bh  <= st4_bh;
      st5_dx  <= st4_dx;
      st5_dy  <= st4_dy;
      st5_ax  <= st4_ax;
      st5_ay  <= st4_ay;

      st6_disc <= st5_ok ? (SQW'(st5_diff) << 2) : '0;
      st6_ok   <= st5_ok;
      st6_a    <= st5_a;
      st6_bh   <= st5_bh;
      st6_dx   <= st5_dx;
      st6_dy   <= st5_dy;
      st6_ax   <= st5_ax;
      st6_ay   <= st5_ay;
    end
  end

  // Square root row.
  logic           sq_v    [RB];
  logic [SQW-1:0] sq_rem  [RB];
  logic [RB-1:0]  sq_root [RB];
  logic           sd_ok   [RB];
  logic [AW-1:0]  sd_a    [RB];
  logic signed [PW-1:0] sd_bh [RB];
  logic signed [W:0] sd_dx [RB];
  logic signed [W:0] sd_dy [RB];
  logic [W-1:0]   sd_ax   [RB];
  logic [W-1:0]   sd_ay   [RB];

  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    logic           cv;
    logic [SQW-1:0] crem;
    logic [RB-1:0]  croot;

    if (g == 0) begin : g_head
      assign cv    = v6;
      assign crem  = st6_disc;
      assign croot = '0;
      always_ff @(posedge clk) begin
        if (en) begin
          sd_ok[g] <= st6_ok;
          sd_a[g]  <= st6_a;
          sd_bh[g] <= st6_bh;
          sd_dx[g] <= st6_dx;
          sd_dy[g] <= st6_dy;
          sd_ax[g] <= st6_ax;
          sd_ay[g] <= st6_ay;
        end
      end
    end else begin : g_body
      assign cv    = sq_v[g-1];
      assign crem  = sq_rem[g-1];
      assign croot = sq_root[g-1];
      always_ff @(posedge clk) begin
        if (en) begin
          sd_ok[g] <= sd_ok[g-1];
          sd_a[g]  <= sd_a[g-1];
          sd_bh[g] <= sd_bh[g-1];
          sd_dx[g] <= sd_dx[g-1];
          sd_dy[g] <= sd_dy[g-1];
          sd_ax[g] <= sd_ax[g-1];
          sd_ay[g] <= sd_ay[g-1];
        end
      end
    end

    csi_sqrt_cell #(
      .VAL_WIDTH (SQW),
      .ROOT_WIDTH(RB),
      .BIT_INDEX (RB - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv),
      .in_rem   (crem),
      .in_root  (croot),
      .out_valid(sq_v[g]),
      .out_rem  (sq_rem[g]),
      .out_root (sq_root[g])
    );
  end

  // Roots, range test and numerator products.
  logic signed [RTW-1:0] rt_b, rt_s, rt_den, rt_n0, rt_n1, rt_t0, rt_t1;
  logic rt_in0, rt_in1;

  always_comb begin
    rt_b   = RTW'(sd_bh[RB-1]) <<< 1;
    rt_s   = $signed(RTW'(sq_root[RB-1]));
    rt_den = $signed(RTW'({sd_a[RB-1], 1'b0}));
    rt_n0  = -rt_b - rt_s;
    rt_n1  = -rt_b + rt_s;
    rt_t0  = rt_den - rt_n0;
    rt_t1  = rt_den - rt_n1;
    rt_in0 = sd_ok[RB-1] && !rt_n0[RTW-1] && !rt_t0[RTW-1];
    rt_in1 = sd_ok[RB-1] && !rt_n1[RTW-1] && !rt_t1[RTW-1];
  end

  logic bv1, bv2, bv3;
  logic [NBW-1:0] bk1_n0, bk1_n1, bk1_den;
  logic [W-1:0] bk1_adx, bk1_ady, bk1_ax, bk1_ay;
  logic bk1_sx, bk1_sy, bk1_h0, bk1_h1;

  logic [NL+W-1:0] bk2_lo [DIV_LANES];
  logic [NH+W-1:0] bk2_hi [DIV_LANES];
  logic [NBW-1:0] bk2_den;
  logic [W-1:0] bk2_ax, bk2_ay;
  logic bk2_sx, bk2_sy, bk2_h0, bk2_h1;

  logic [DIV_LANES-1:0][NUMW-1:0] bk3_num;
  logic [NBW-1:0] bk3_den;
  logic [W-1:0] bk3_ax, bk3_ay;
  logic bk3_sx, bk3_sy, bk3_h0, bk3_h1;

  logic [NBW-1:0] bk1_lane_n [DIV_LANES];
  logic [W-1:0]   bk1_lane_d [DIV_LANES];

  assign bk1_lane_n[0] = bk1_n0;
  assign bk1_lane_n[1] = bk1_n0;
  assign bk1_lane_n[2] = bk1_n1;
  assign bk1_lane_n[3] = bk1_n1;
  assign bk1_lane_d[0] = bk1_adx;
  assign bk1_lane_d[1] = bk1_ady;
  assign bk1_lane_d[2] = bk1_adx;
  assign bk1_lane_d[3] = bk1_ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv1 <= 1'b0;
      bv2 <= 1'b0;
      bv3 <= 1'b0;
    end else if (en) begin
      bv1 <= sq_v[RB-1];
      bv2 <= bv1;
      bv3 <= bv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bk1_n0  <= rt_in0 ? rt_n0[NBW-1:0] : rt_n1[NBW-1:0];
      bk1_n1  <= rt_n1[NBW-1:0];
      bk1_den <= {sd_a[RB-1], 1'b0};
      bk1_adx <= sd_dx[RB-1][W] ? W'(-sd_dx[RB-1]) : W'(sd_dx[RB-1]);
      bk1_ady <= sd_dy[RB-1][W] ? W'(-sd_dy[RB-1]) : W'(sd_dy[RB-1]);
      bk1_sx  <= sd_dx[RB-1][W];
      bk1_sy  <= sd_dy[RB-1][W];
      bk1_ax  <= sd_ax[RB-1];
      bk1_ay  <= sd_ay[RB-1];
      bk1_h0  <= rt_in0 || rt_in1;
      bk1_h1  <= rt_in0 && rt_in1;

      for (int l = 0; l < DIV_LANES; l++) begin
        bk2_lo[l] <= (NL+W)'(bk1_lane_n[l][NL-1:0]) * (NL+W)'(bk1_lane_d[l]);
        bk2_hi[l] <= (NH+W)'(bk1_lane_n[l][NBW-1:NL]) * (NH+W)'(bk1_lane_d[l]);
      end
      bk2_den <= bk1_den;
      bk2_ax  <= bk1_ax;
      bk2_ay  <= bk1_ay;
      bk2_sx  <= bk1_sx;
      bk2_sy  <= bk1_sy;
      bk2_h0  <= bk1_h0;
      bk2_h1  <= bk1_h1;

      for (int l = 0; l < DIV_LANES; l++) begin
        bk3_num[l] <= NUMW'(bk2_lo[l]) + (NUMW'(bk2_hi[l]) << NL);
      end
      bk3_den <= bk2_den;
      bk3_ax  <= bk2_ax;
      bk3_ay  <= bk2_ay;
      bk3_sx  <= bk2_sx;
      bk3_sy  <= bk2_sy;
      bk3_h0  <= bk2_h0;
      bk3_h1  <= bk2_h1;
    end
  end

  // Division row.
  logic                           dv_v   [QB];
  logic [NBW-1:0]                 dv_den [QB];
  logic [DIV_LANES-1:0][NUMW-1:0] dv_rem [QB];
  logic [DIV_LANES-1:0][QB-1:0]   dv_quo [QB];
  logic [W-1:0] dd_ax [QB];
  logic [W-1:0] dd_ay [QB];
  logic dd_sx [QB];
  logic dd_sy [QB];
  logic dd_h0 [QB];
  logic dd_h1 [QB];

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic                           cv;
    logic [NBW-1:0]                 cden;
    logic [DIV_LANES-1:0][NUMW-1:0] crem;
    logic [DIV_LANES-1:0][QB-1:0]   cquo;

    if (g == 0) begin : g_head
      assign cv   = bv3;
      assign cden = bk3_den;
      assign crem = bk3_num;
      assign cquo = '0;
      always_ff @(posedge clk) begin
        if (en) begin
          dd_ax[g] <= bk3_ax;
          dd_ay[g] <= bk3_ay;
          dd_sx[g] <= bk3_sx;
          dd_sy[g] <= bk3_sy;
          dd_h0[g] <= bk3_h0;
          dd_h1[g] <= bk3_h1;
        end
      end
    end else begin : g_body
      assign cv   = dv_v[g-1];
      assign cden = dv_den[g-1];
      assign crem = dv_rem[g-1];
      assign cquo = dv_quo[g-1];
      always_ff @(posedge clk) begin
        if (en) begin
          dd_ax[g] <= dd_ax[g-1];
          dd_ay[g] <= dd_ay[g-1];
          dd_sx[g] <= dd_sx[g-1];
          dd_sy[g] <= dd_sy[g-1];
          dd_h0[g] <= dd_h0[g-1];
          dd_h1[g] <= dd_h1[g-1];
        end
      end
    end

    csi_div_cell #(
      .NUM_WIDTH(NUMW),
      .DEN_WIDTH(NBW),
      .QUO_WIDTH(QB),
      .BIT_INDEX(QB - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv),
      .in_den   (cden),
      .in_rem   (crem),
      .in_quo   (cquo),
      .out_valid(dv_v[g]),
      .out_den  (dv_den[g]),
      .out_rem  (dv_rem[g]),
      .out_quo  (dv_quo[g])
    );
  end

  // Truncation toward zero and result packing.
  logic [W-1:0] fin_p0   [DIV_LANES];
  logic         fin_sg   [DIV_LANES];
  logic         fin_keep [DIV_LANES];
  logic [W-1:0] fin_c    [DIV_LANES];
  logic [1:0]   fin_count;
  logic [OUT_W-1:0] fin_data;

  always_comb begin
    logic signed [W+1:0] qs, fl, vv, rr;
    logic nz;
    fin_p0[0]   = dd_ax[QB-1];
    fin_p0[1]   = dd_ay[QB-1];
    fin_p0[2]   = dd_ax[QB-1];
    fin_p0[3]   = dd_ay[QB-1];
    fin_sg[0]   = dd_sx[QB-1];
    fin_sg[1]   = dd_sy[QB-1];
    fin_sg[2]   = dd_sx[QB-1];
    fin_sg[3]   = dd_sy[QB-1];
    fin_keep[0] = dd_h0[QB-1];
    fin_keep[1] = dd_h0[QB-1];
    fin_keep[2] = dd_h1[QB-1];
    fin_keep[3] = dd_h1[QB-1];
    for (int l = 0; l < DIV_LANES; l++) begin
      nz = dv_rem[QB-1][l] != '0;
      qs = $signed({2'b00, dv_quo[QB-1][l]});
      fl = fin_sg[l] ? (-qs - $signed({{(W+1){1'b0}}, nz})) : qs;
      vv = fl + $signed({{2{fin_p0[l][W-1]}}, fin_p0[l]});
      rr = vv + $signed({{(W+1){1'b0}}, nz & vv[W+1]});
      fin_c[l] = fin_keep[l] ? rr[W-1:0] : '0;
    end
    if (dd_h1[QB-1]) begin
      fin_count = 2'd2;
    end else if (dd_h0[QB-1]) begin
      fin_count = 2'd1;
    end else begin
      fin_count = 2'd0;
    end
    fin_data = OUT_W'({fin_c[3], fin_c[2], fin_c[1], fin_c[0], fin_count});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (en) begin
      out_v  <= dv_v[QB-1];
      skid_v <= out_v && !m_tready;
    end else if (m_tready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= fin_data;
      skid  <= out_d;
    end
  end

endmodule
`default_nettype wire
